### design/icmp_echo_responder_assert.svh
// Assertion macros used by the ICMP echo responder top level
`ifndef ICMP_ECHO_RESPONDER_ASSERT_SVH
`define ICMP_ECHO_RESPONDER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define ICMP_ER_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icmp_er: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define ICMP_ER_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icmp_er: next-cycle check failed");

`endif

### design/icmp_er_pkg.sv
// Types, constants and helper functions of the ICMP echo responder
package icmp_er_pkg;

  localparam int HDR_LEN = 42;
  localparam int POS_W   = 6;

  localparam logic [POS_W-1:0] HDR_LEN_POS  = 6'd42;
  localparam logic [POS_W-1:0] HDR_LAST_POS = 6'd41;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_SRC_MAC   = 6'd6;
  localparam logic [POS_W-1:0] POS_MAC_END   = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_PROTO     = 6'd23;
  localparam logic [POS_W-1:0] POS_SRC_IP    = 6'd26;
  localparam logic [POS_W-1:0] POS_IP_END    = 6'd34;
  localparam logic [POS_W-1:0] POS_ICMP_TYPE = 6'd34;
  localparam logic [POS_W-1:0] POS_CSUM_HI   = 6'd36;
  localparam logic [POS_W-1:0] POS_CSUM_LO   = 6'd37;

  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  ICMP_TYPE_REQUEST = 8'd8;
  localparam logic [7:0]  ICMP_TYPE_REPLY   = 8'd0;
  localparam logic [15:0] CSUM_OLD_WORD     = 16'h0800;

  localparam logic [1:0] VERDICT_FORWARD = 2'd0;
  localparam logic [1:0] VERDICT_REPLY   = 2'd1;
  localparam logic [1:0] VERDICT_DROP    = 2'd2;
  localparam logic [1:0] VERDICT_RSVD    = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SRIOV_ENABLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRIOV_DEST_MAC = 1'd1;

  // One queue entry: a header burst command or a body byte
  typedef struct packed {
    logic             is_hdr;
    logic [7:0]       data;
    logic             last;
    logic [1:0]       verdict;
    logic [POS_W-1:0] end_idx;
  } q_entry_t;

  // Header buffer write port
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [7:0]       data;
  } hdr_wr_t;

  // Header fields captured for the rewrite
  typedef struct packed {
    logic [11:0][7:0] mac;
    logic [7:0][7:0]  ip;
    logic [15:0]      csum;
  } hdr_cap_t;

  // Front status seen by the top level
  typedef struct packed {
    logic busy;
    logic hdr_phase;
  } fe_status_t;

  // Incremental ICMP checksum update for type 8 -> type 0
  function automatic logic [15:0] csum_reply(input logic [15:0] c);
    logic [16:0] sum;
    logic [15:0] r;
    sum = {1'b0, ~c} + {1'b0, ~CSUM_OLD_WORD};
    r   = sum[15:0] + {15'd0, sum[16]};
    return ~r;
  endfunction

endpackage

### design/icmp_er_queue.sv
// Short FIFO between the frame front end and the emitter
module icmp_er_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  icmp_er_pkg::q_entry_t wdata,
  input  logic                  pop,
  output icmp_er_pkg::q_entry_t head,
  output logic                  nonempty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  icmp_er_pkg::q_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign nonempty = (count_r != '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign head     = entries_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### design/icmp_er_front.sv
// Front end: collects header bytes, classifies the frame, queues work
module icmp_er_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [7:0]              in_frame_byte,
  input  logic                    in_frame_last,
  output logic                    in_stall,
  input  logic                    q_full,
  output logic                    q_push,
  output icmp_er_pkg::q_entry_t   q_wdata,
  output icmp_er_pkg::hdr_wr_t    hdr_wr,
  output icmp_er_pkg::hdr_cap_t   cap,
  output icmp_er_pkg::fe_status_t status,
  input  logic                    hdr_done
);

  logic [icmp_er_pkg::POS_W-1:0] pos_r;
  logic [1:0]                    verd_r;
  logic                          busy_r;
  icmp_er_pkg::hdr_cap_t         cap_r;
  logic [15:0]                   etype_r;
  logic [7:0]                    proto_r;
  logic [7:0]                    icmp_type_r;

  logic                          hdr_phase;
  logic                          accept;
  logic [1:0]                    verd_new;
  logic [icmp_er_pkg::POS_W-1:0] ip_off;

  assign hdr_phase = (pos_r < icmp_er_pkg::HDR_LEN_POS);
  assign in_stall  = q_full || (hdr_phase && busy_r);
  assign accept    = in_valid && !in_stall;
  assign ip_off    = pos_r - icmp_er_pkg::POS_SRC_IP;

  assign cap    = cap_r;
  assign status = '{busy: busy_r, hdr_phase: hdr_phase};

  // Classify from the captured header fields
  always_comb begin
    priority if (etype_r != icmp_er_pkg::ETHERTYPE_IPV4) begin
      verd_new = icmp_er_pkg::VERDICT_DROP;
    end else if (proto_r != icmp_er_pkg::PROTO_ICMP ||
                 icmp_type_r != icmp_er_pkg::ICMP_TYPE_REQUEST) begin
      verd_new = icmp_er_pkg::VERDICT_FORWARD;
    end else begin
      verd_new = icmp_er_pkg::VERDICT_REPLY;
    end
  end

  // Header buffer write and queue push
  always_comb begin
    hdr_wr.en   = accept && hdr_phase;
    hdr_wr.addr = pos_r;
    hdr_wr.data = in_frame_byte;

    q_push          = 1'b0;
    q_wdata.is_hdr  = 1'b0;
    q_wdata.data    = in_frame_byte;
    q_wdata.last    = in_frame_last;
    q_wdata.verdict = verd_r;
    q_wdata.end_idx = pos_r;
    if (accept) begin
      if (!hdr_phase) begin
        q_push = 1'b1;
      end else if (pos_r == icmp_er_pkg::HDR_LAST_POS) begin
        q_push          = 1'b1;
        q_wdata.is_hdr  = 1'b1;
        q_wdata.data    = '0;
        q_wdata.verdict = verd_new;
      end else if (in_frame_last) begin
        q_push          = 1'b1;
        q_wdata.is_hdr  = 1'b1;
        q_wdata.data    = '0;
        q_wdata.verdict = icmp_er_pkg::VERDICT_DROP;
      end
    end
  end

  // Capture fields needed for classification and rewrite
  always_ff @(posedge clk) begin
    if (accept && hdr_phase) begin
      if (pos_r < icmp_er_pkg::POS_MAC_END) begin
        cap_r.mac[pos_r[3:0]] <= in_frame_byte;
      end
      if (pos_r >= icmp_er_pkg::POS_SRC_IP && pos_r < icmp_er_pkg::POS_IP_END) begin
        cap_r.ip[ip_off[2:0]] <= in_frame_byte;
      end
      if (pos_r == icmp_er_pkg::POS_ETYPE_HI) begin
        etype_r[15:8] <= in_frame_byte;
      end
      if (pos_r == icmp_er_pkg::POS_ETYPE_LO) begin
        etype_r[7:0] <= in_frame_byte;
      end
      if (pos_r == icmp_er_pkg::POS_PROTO) begin
        proto_r <= in_frame_byte;
      end
      if (pos_r == icmp_er_pkg::POS_ICMP_TYPE) begin
        icmp_type_r <= in_frame_byte;
      end
      if (pos_r == icmp_er_pkg::POS_CSUM_HI) begin
        cap_r.csum[15:8] <= in_frame_byte;
      end
      if (pos_r == icmp_er_pkg::POS_CSUM_LO) begin
        cap_r.csum[7:0] <= in_frame_byte;
      end
    end
  end

  // Track byte position, frame verdict and header ownership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      verd_r <= icmp_er_pkg::VERDICT_FORWARD;
      busy_r <= 1'b0;
    end else begin
      if (hdr_done) begin
        busy_r <= 1'b0;
      end
      if (accept) begin
        if (!hdr_phase) begin
          if (in_frame_last) begin
            pos_r <= '0;
          end
        end else if (pos_r == icmp_er_pkg::HDR_LAST_POS) begin
          verd_r <= verd_new;
          busy_r <= 1'b1;
          pos_r  <= in_frame_last ? '0 : icmp_er_pkg::HDR_LEN_POS;
        end else if (in_frame_last) begin
          verd_r <= icmp_er_pkg::VERDICT_DROP;
          busy_r <= 1'b1;
          pos_r  <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

endmodule

### design/icmp_er_back.sv
// Back end: header buffer, header replay with rewrite, output register
module icmp_er_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_nonempty,
  input  icmp_er_pkg::q_entry_t q_head,
  output logic                  q_pop,
  input  icmp_er_pkg::hdr_wr_t  hdr_wr,
  input  icmp_er_pkg::hdr_cap_t cap,
  input  logic                  sriov_enable,
  input  logic [47:0]           sriov_dest_mac,
  output logic                  hdr_done,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic [1:0]            out_verdict
);

  logic [7:0] hdr_mem [icmp_er_pkg::HDR_LEN];
  logic [7:0] rd_r;

  // Header replay sequencer
  logic                          hdr_act_r;
  logic [icmp_er_pkg::POS_W-1:0] hdr_idx_r;
  logic [icmp_er_pkg::POS_W-1:0] hdr_end_r;
  logic                          hdr_last_r;
  logic [1:0]                    hdr_verd_r;

  // Read stage
  logic                          b_valid_r;
  logic                          b_is_hdr_r;
  logic [icmp_er_pkg::POS_W-1:0] b_idx_r;
  logic [7:0]                    b_byte_r;
  logic                          b_last_r;
  logic                          b_final_r;
  logic [1:0]                    b_verd_r;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_verd_r;

  logic       out_adv, b_adv, hdr_at_end;
  logic [7:0] hdr_byte;
  logic [3:0] mac_sel;
  logic [icmp_er_pkg::POS_W-1:0] ip_off;
  logic [2:0] ip_sel;
  logic [2:0] cfg_sel;
  logic [5:0][7:0] cfg_mac;
  logic [15:0] csum_new;

  assign out_adv    = !out_valid_r || !out_stall;
  assign b_adv      = !b_valid_r || out_adv;
  assign q_pop      = b_adv && !hdr_act_r && q_nonempty;
  assign hdr_at_end = (hdr_idx_r == hdr_end_r);
  assign hdr_done   = out_adv && b_valid_r && b_is_hdr_r && b_final_r;

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;
  assign out_verdict = out_verd_r;

  // Header buffer write
  always_ff @(posedge clk) begin
    if (hdr_wr.en) begin
      hdr_mem[hdr_wr.addr] <= hdr_wr.data;
    end
  end

  // Header buffer registered read
  always_ff @(posedge clk) begin
    if (b_adv) begin
      rd_r <= hdr_mem[hdr_idx_r];
    end
  end

  // Step through a header burst or pass a body byte into the read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_act_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (b_adv) begin
      if (hdr_act_r) begin
        b_valid_r <= 1'b1;
        if (hdr_at_end) begin
          hdr_act_r <= 1'b0;
        end
      end else if (q_pop && !q_head.is_hdr) begin
        b_valid_r <= 1'b1;
      end else begin
        b_valid_r <= 1'b0;
        if (q_pop) begin
          hdr_act_r <= 1'b1;
        end
      end
    end
  end

  // Read stage payload and burst bookkeeping
  always_ff @(posedge clk) begin
    if (b_adv) begin
      if (hdr_act_r) begin
        b_is_hdr_r <= 1'b1;
        b_idx_r    <= hdr_idx_r;
        b_byte_r   <= '0;
        b_last_r   <= hdr_at_end && hdr_last_r;
        b_final_r  <= hdr_at_end;
        b_verd_r   <= hdr_verd_r;
        hdr_idx_r  <= hdr_idx_r + 1'b1;
      end else begin
        b_is_hdr_r <= 1'b0;
        b_idx_r    <= '0;
        b_byte_r   <= q_head.data;
        b_last_r   <= q_head.last;
        b_final_r  <= 1'b0;
        b_verd_r   <= q_head.verdict;
        if (q_pop) begin
          hdr_idx_r  <= '0;
          hdr_end_r  <= q_head.end_idx;
          hdr_last_r <= q_head.last;
          hdr_verd_r <= q_head.verdict;
        end
      end
    end
  end

  // Rewrite one header byte by its position, the frame verdict and the SR-IOV enable
  assign mac_sel  = (b_idx_r < icmp_er_pkg::POS_SRC_MAC) ? b_idx_r[3:0] + 4'd6
                                                         : b_idx_r[3:0] - 4'd6;
  assign ip_off   = b_idx_r - icmp_er_pkg::POS_SRC_IP;
  assign ip_sel   = ip_off[2:0] ^ 3'b100;
  assign cfg_sel  = 3'd5 - b_idx_r[2:0];
  assign cfg_mac  = sriov_dest_mac;
  assign csum_new = icmp_er_pkg::csum_reply(cap.csum);

  always_comb begin
    hdr_byte = rd_r;
    unique case (b_verd_r)
      icmp_er_pkg::VERDICT_FORWARD: begin
        if (sriov_enable) begin
          if (b_idx_r < icmp_er_pkg::POS_SRC_MAC) begin
            hdr_byte = cfg_mac[cfg_sel];
          end else if (b_idx_r < icmp_er_pkg::POS_MAC_END) begin
            hdr_byte = cap.mac[mac_sel];
          end
        end
      end
      icmp_er_pkg::VERDICT_REPLY: begin
        priority if (b_idx_r < icmp_er_pkg::POS_MAC_END) begin
          hdr_byte = cap.mac[mac_sel];
        end else if (b_idx_r >= icmp_er_pkg::POS_SRC_IP &&
                     b_idx_r < icmp_er_pkg::POS_IP_END) begin
          hdr_byte = cap.ip[ip_sel];
        end else if (b_idx_r == icmp_er_pkg::POS_ICMP_TYPE) begin
          hdr_byte = icmp_er_pkg::ICMP_TYPE_REPLY;
        end else if (b_idx_r == icmp_er_pkg::POS_CSUM_HI) begin
          hdr_byte = csum_new[15:8];
        end else if (b_idx_r == icmp_er_pkg::POS_CSUM_LO) begin
          hdr_byte = csum_new[7:0];
        end else begin
          hdr_byte = rd_r;
        end
      end
      default: begin
        hdr_byte = rd_r;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_byte_r <= b_is_hdr_r ? hdr_byte : b_byte_r;
      out_last_r <= b_last_r;
      out_verd_r <= b_verd_r;
    end
  end

endmodule

### design/icmp_echo_responder.sv
// Top level of the ICMP echo responder: configuration, front, queue, back
//
//   Channel  Direction  Handshake             Transaction
//   in_      input      in_valid / in_stall   one frame byte and last flag
//   out_     output     out_valid / out_stall one frame byte, last flag, verdict
//   cfg_     input      cfg_valid / cfg_ready register index and write data
//
// Frame bytes are taken one per cycle unless stalled. The first 42 bytes fill the
// header buffer; the header leaves via the replay sequencer, read stage and output
// register one byte per cycle unless out_stall, and body bytes follow it.
// The next frame's header bytes wait until the previous header's last byte has
// entered the output register, since the header buffer holds one header at a time.
// Reset is synchronous; no clearing pass is needed. out_stall holds only the
// emitter; the front keeps taking body bytes until the queue fills.
`include "icmp_echo_responder_assert.svh"

module icmp_echo_responder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_frame_byte,
  input  logic                              in_frame_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_last,
  output logic [1:0]                        out_verdict,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [icmp_er_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]                       cfg_data
);

  logic                    sriov_enable_r;
  logic [47:0]             sriov_dest_mac_r;

  logic                    q_push, q_pop, q_full, q_nonempty;
  icmp_er_pkg::q_entry_t   q_wdata, q_head;
  icmp_er_pkg::hdr_wr_t    hdr_wr;
  icmp_er_pkg::hdr_cap_t   cap;
  icmp_er_pkg::fe_status_t fe_status;
  logic                    hdr_done;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sriov_enable_r   <= 1'b0;
      sriov_dest_mac_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        icmp_er_pkg::REG_SRIOV_ENABLE:   sriov_enable_r   <= cfg_data[0];
        icmp_er_pkg::REG_SRIOV_DEST_MAC: sriov_dest_mac_r <= cfg_data;
        default: ;
      endcase
    end
  end

  icmp_er_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_byte (in_frame_byte),
    .in_frame_last (in_frame_last),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .hdr_wr        (hdr_wr),
    .cap           (cap),
    .status        (fe_status),
    .hdr_done      (hdr_done)
  );

  icmp_er_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .pop      (q_pop),
    .head     (q_head),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  icmp_er_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .hdr_wr         (hdr_wr),
    .cap            (cap),
    .sriov_enable   (sriov_enable_r),
    .sriov_dest_mac (sriov_dest_mac_r),
    .hdr_done       (hdr_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_verdict    (out_verdict)
  );

  // Never push into a full queue
  `ICMP_ER_ASSERT_IMP(a_no_push_when_full, q_push, !q_full)
  // A header burst only finishes while the front owns a pending header
  `ICMP_ER_ASSERT_IMP(a_hdr_done_owned, hdr_done, fe_status.busy)
  // Header buffer is never written while a header is being replayed
  `ICMP_ER_ASSERT_IMP(a_no_hdr_overwrite, hdr_wr.en, !fe_status.busy)
  // Only defined verdicts leave the block
  `ICMP_ER_ASSERT_IMP(a_verdict_legal, out_valid, out_verdict != icmp_er_pkg::VERDICT_RSVD)

endmodule
